// ===== sv/lpl_pkg.sv =====
package lpl_pkg;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FIND  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
        logic [2:0]  slot_index;
        logic [7:0]  pinned_mask;
    } lpl_req_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  found_index;
        logic [63:0] removed_value;
        logic [3:0]  entry_count;
        logic        is_empty;
        logic        is_full;
    } lpl_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } lpl_state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic update;
    } lpl_cmd_t;

endpackage

// ===== sv/lpl_ctrl.sv =====
module lpl_ctrl
    import lpl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lpl_cmd_t cmd
);

    lpl_state_t state_reg;
    lpl_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    // result register can take a new result this cycle
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.load   = 1'b0;
        cmd.match  = 1'b0;
        cmd.update = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_MATCH:
            begin
                cmd.match = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.update = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.update)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== sv/lpl_datapath.sv =====
module lpl_datapath
    import lpl_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  lpl_cmd_t cmd,
    input  lpl_req_t req,
    output lpl_rsp_t rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 4) ? CW : 4;

    lpl_req_t          req_reg;
    logic [63:0]       entry_reg [DEPTH];
    logic [63:0]       entry_next [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [DEPTH-1:0]  match_reg;
    logic [DEPTH-1:0]  free_reg;
    lpl_rsp_t          rsp_reg;
    lpl_rsp_t          rsp_next;

    logic              hit;
    logic [IW-1:0]     hit_slot;
    logic              victim_any;
    logic [IW-1:0]     victim_slot;
    logic              rm_en;
    logic [IW-1:0]     rm_slot;
    logic              app_en;
    logic [CW-1:0]     app_pos;
    logic              clr;
    logic [XW-1:0]     count_x;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     hit_x;
    logic [XW-1:0]     count_next_x;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    // parallel compare of every live slot, plus which slots may be evicted
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        logic live;
        logic pin;
        assign live = CW'(g) < count_reg;
        if (g < 8)
        begin : g_pin
            assign pin = req_reg.pinned_mask[g];
        end
        else
        begin : g_nopin
            assign pin = 1'b0;
        end
        always_ff @(posedge clk)
        begin
            if (cmd.match)
            begin
                match_reg[g] <= live && (entry_reg[g] == req_reg.key);
                free_reg[g]  <= live && !pin;
            end
        end
    end

    // lowest set bit wins
    always_comb
    begin
        hit         = 1'b0;
        hit_slot    = '0;
        victim_any  = 1'b0;
        victim_slot = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit      = 1'b1;
                hit_slot = IW'(i);
            end
            if (free_reg[i])
            begin
                victim_any  = 1'b1;
                victim_slot = IW'(i);
            end
        end
    end

    assign count_x = XW'(count_reg);
    assign idx_x   = XW'(req_reg.slot_index);
    assign hit_x   = XW'(hit_slot);

    always_comb
    begin
        rm_en      = 1'b0;
        rm_slot    = '0;
        app_en     = 1'b0;
        app_pos    = count_reg;
        clr        = 1'b0;
        count_next = count_reg;
        rsp_next   = '0;
        case (req_reg.opcode)
            OP_PUSH:
            begin
                if (hit)
                begin
                    rm_en   = 1'b1;
                    rm_slot = hit_slot;
                    app_en  = 1'b1;
                    app_pos = count_reg - CW'(1);
                end
                else if (count_reg != CW'(DEPTH))
                begin
                    app_en     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else if (victim_any)
                begin
                    rm_en   = 1'b1;
                    rm_slot = victim_slot;
                    app_en  = 1'b1;
                    app_pos = count_reg - CW'(1);
                end
                else
                begin
                    rsp_next.status = 1'b1;
                end
            end
            OP_POP:
            begin
                if (idx_x < count_x)
                begin
                    rm_en                  = 1'b1;
                    rm_slot                = IW'(req_reg.slot_index);
                    rsp_next.removed_value = entry_reg[rm_slot];
                    count_next             = count_reg - CW'(1);
                end
                else
                begin
                    rsp_next.status = 1'b1;
                end
            end
            OP_FIND:
            begin
                if (hit)
                begin
                    rsp_next.found_index = hit_x[2:0];
                end
                else
                begin
                    rsp_next.status = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                clr        = 1'b1;
                count_next = '0;
            end
            default:
            begin
                clr = 1'b0;
            end
        endcase
        count_next_x         = XW'(count_next);
        rsp_next.entry_count = count_next_x[3:0];
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.is_full     = (count_next == CW'(DEPTH));
    end

    // close the gap by shifting down from the removed slot, then place the key; a clear zeroes every slot
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (rm_en && (IW'(i) >= rm_slot))
            begin
                entry_next[i] = (i < DEPTH - 1) ? entry_reg[(i + 1) % DEPTH] : 64'd0;
            end
            if (app_en && (CW'(i) == app_pos))
            begin
                entry_next[i] = req_reg.key;
            end
            if (clr)
            begin
                entry_next[i] = 64'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= 64'd0;
            end
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== sv/lru_page_list_with_pin_skip.sv =====
// channel  | valid     | ready     | payload
// ---------+-----------+-----------+---------------------
// request  | req_valid | req_ready | req (lpl_req_t)
// response | rsp_valid | rsp_ready | rsp (lpl_rsp_t)
//
// one request is taken at a time, the next only after the last is done: capture, parallel key compare over
// all slots, then a shift/append update of the slot registers
// the update waits while an earlier response has not been transferred
// reset clears the list and count; the first request may follow at once
module lru_page_list_with_pin_skip
    import lpl_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lpl_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lpl_rsp_t rsp
);

    lpl_cmd_t cmd;

    lpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    lpl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== sv/lpl_checker.sv =====
module lpl_checker
    import lpl_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input lpl_rsp_t rsp
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |-> rsp.entry_count == 4'd0 && !rsp.is_full)
        else $error("empty flag disagrees with count");

    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.removed_value != 64'd0 |-> !rsp.status && rsp.found_index == 3'd0)
        else $error("removed key on a failed or non-pop result");

    // one item in flight: no new request is taken right after one is
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

endmodule

bind lru_page_list_with_pin_skip lpl_checker u_lpl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
